// File: sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the compensation block checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion that is switched off while reset is held.
`define BPTC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Assertion that is evaluated at every clock edge, reset included.
`define BPTC_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: sv/bptc_pkg.sv
// ---------------------------------------------------------------------------
// bptc_pkg
// Types, register indexes and calibration unpacking for the compensation.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bptc_pkg;

  localparam int LATENCY = 11;
  localparam int HORNER_STAGES = 7;

  typedef enum logic [1:0] {
    CFG_CALIB_LOW  = 2'd0,
    CFG_CALIB_MID  = 2'd1,
    CFG_CALIB_HIGH = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic [23:0] press_adc;
    logic [23:0] temp_adc;
  } in_payload_t;

  typedef struct packed {
    logic signed [23:0] temperature_out;
    logic [23:0]        pressure_out;
    logic               saturated;
  } out_payload_t;

  typedef struct packed {
    logic [15:0]        t1;
    logic [15:0]        t2;
    logic signed [7:0]  t3;
    logic signed [15:0] p1;
    logic signed [15:0] p2;
    logic signed [7:0]  p3;
    logic signed [7:0]  p4;
    logic [15:0]        p5;
    logic [15:0]        p6;
    logic signed [7:0]  p7;
    logic signed [7:0]  p8;
    logic signed [15:0] p9;
    logic signed [7:0]  p10;
    logic signed [7:0]  p11;
  } calib_t;

  typedef struct packed {
    logic               valid;
    logic               sat;
    logic signed [23:0] t;
  } temp_res_t;

  typedef struct packed {
    logic signed [32:0]  k3;
    logic signed [53:0]  k2;
    logic signed [83:0]  k1;
    logic signed [111:0] k0;
  } coef_t;

  function automatic calib_t unpack_calib(input logic [63:0] lo, input logic [63:0] mid,
                                          input logic [39:0] hi);
    calib_t c;
    c.t1  = lo[15:0];
    c.t2  = lo[31:16];
    c.t3  = $signed(lo[39:32]);
    c.p1  = $signed(lo[55:40]);
    c.p2  = $signed({mid[7:0], lo[63:56]});
    c.p3  = $signed(mid[15:8]);
    c.p4  = $signed(mid[23:16]);
    c.p5  = mid[39:24];
    c.p6  = mid[55:40];
    c.p7  = $signed(mid[63:56]);
    c.p8  = $signed(hi[7:0]);
    c.p9  = $signed(hi[23:8]);
    c.p10 = $signed(hi[31:24]);
    c.p11 = $signed(hi[39:32]);
    return c;
  endfunction

endpackage

`default_nettype wire

// File: sv/bptc_temp.sv
// ---------------------------------------------------------------------------
// bptc_temp
// Four-stage temperature quadratic with rounding and saturation.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bptc_temp (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic [23:0]        raw_t,
  input  wire bptc_pkg::calib_t   calib,
  output bptc_pkg::temp_res_t     res
);

  logic [3:0]         v_r;
  logic signed [24:0] d_r;
  logic signed [41:0] m1_r, m1_r3;
  logic signed [49:0] dd_r;
  logic signed [57:0] ddt3_r;
  logic signed [23:0] t_r;
  logic               sat_r;

  logic signed [24:0] d_nxt;
  logic signed [61:0] num;
  logic signed [61:0] rnd;
  logic signed [29:0] tq;
  logic signed [23:0] t_nxt;
  logic               sat_nxt;

  assign d_nxt = $signed({1'b0, raw_t}) - $signed({1'b0, calib.t1, 8'h00});
  assign num   = (62'(m1_r3) <<< 18) + 62'(ddt3_r);
  assign rnd   = num + 62'sh8000_0000;
  assign tq    = $signed(rnd[61:32]);

  always_comb begin
    sat_nxt = 1'b0;
    t_nxt   = tq[23:0];
    if (tq > 30'sd8388607) begin
      t_nxt   = 24'sh7F_FFFF;
      sat_nxt = 1'b1;
    end else if (tq < -30'sd8388608) begin
      t_nxt   = 24'sh80_0000;
      sat_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    d_r    <= d_nxt;
    m1_r   <= 42'(d_r) * 42'($signed({1'b0, calib.t2}));
    dd_r   <= 50'(d_r) * 50'(d_r);
    m1_r3  <= m1_r;
    ddt3_r <= 58'(dd_r) * 58'(calib.t3);
    t_r    <= t_nxt;
    sat_r  <= sat_nxt;
  end

  assign res.valid = v_r[3];
  assign res.sat   = sat_r;
  assign res.t     = t_r;

endmodule

`default_nettype wire

// File: sv/bptc_coef.sv
// ---------------------------------------------------------------------------
// bptc_coef
// Four-stage build of the pressure polynomial coefficients from the raw
// pressure, one per power of temperature.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bptc_coef (
  input  wire logic             clk,
  input  wire logic [23:0]      up,
  input  wire bptc_pkg::calib_t calib,
  output bptc_pkg::coef_t       coef
);

  logic signed [24:0] ups;
  logic signed [16:0] p1o, p2o;

  logic [47:0]        u2_r;
  logic signed [40:0] p1u_r, p2u_r, p1u_r2, p2u_r2;
  logic signed [31:0] p3u_r, p4u_r, p11u_r;
  logic signed [63:0] p9u2_r;
  logic signed [56:0] p10u2_r;
  logic signed [55:0] p11lo_r, p11hi_r;
  logic signed [32:0] k3_r2, k3_r3;
  logic signed [53:0] k2_r2, k2_r3;
  logic signed [83:0] k1_r3;
  logic signed [111:0] k0_r3;
  bptc_pkg::coef_t    coef_r;

  assign ups = $signed({1'b0, up});
  assign p1o = 17'(calib.p1) - 17'sd16384;
  assign p2o = 17'(calib.p2) - 17'sd16384;

  always_ff @(posedge clk) begin
    u2_r    <= 48'(up) * 48'(up);
    p1u_r   <= 41'(p1o) * 41'(ups);
    p2u_r   <= 41'(p2o) * 41'(ups);
    p3u_r   <= 32'(calib.p3) * 32'(ups);
    p4u_r   <= 32'(calib.p4) * 32'(ups);
    p11u_r  <= 32'(calib.p11) * 32'(ups);

    p9u2_r  <= 64'(calib.p9) * 64'($signed({1'b0, u2_r}));
    p10u2_r <= 57'(calib.p10) * 57'($signed({1'b0, u2_r}));
    p11lo_r <= 56'(p11u_r) * 56'($signed({1'b0, u2_r[23:0]}));
    p11hi_r <= 56'(p11u_r) * 56'($signed({1'b0, u2_r[47:24]}));
    p1u_r2  <= p1u_r;
    p2u_r2  <= p2u_r;
    k3_r2   <= (33'(calib.p8) <<< 22) + 33'(p4u_r);
    k2_r2   <= (54'(calib.p7) <<< 45) + (54'(p3u_r) <<< 21);

    k3_r3   <= k3_r2;
    k2_r3   <= k2_r2;
    k1_r3   <= (84'(calib.p6) << 63) + (84'(p2u_r2) << 40) + (84'(p10u2_r) << 21);
    k0_r3   <= (112'(calib.p5) << 88) + (112'(p1u_r2) << 65) + (112'(p9u2_r) << 37)
             + (112'(p11hi_r) << 44) + (112'(p11lo_r) << 20);

    coef_r.k3 <= k3_r3;
    coef_r.k2 <= k2_r3;
    coef_r.k1 <= k1_r3;
    coef_r.k0 <= k0_r3;
  end

  assign coef = coef_r;

endmodule

`default_nettype wire

// File: sv/bptc_horner.sv
// ---------------------------------------------------------------------------
// bptc_horner
// Seven-stage evaluation of the pressure cubic in temperature, with the wide
// products split into partial products, then rounding and saturation.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bptc_horner (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire bptc_pkg::temp_res_t temp,
  input  wire bptc_pkg::coef_t     coef,
  output logic                     out_valid,
  output bptc_pkg::out_payload_t   out_payload
);

  logic [bptc_pkg::HORNER_STAGES-1:0] v_r;
  logic signed [23:0] t_r   [bptc_pkg::HORNER_STAGES-1];
  logic               sat_r [bptc_pkg::HORNER_STAGES-1];

  logic signed [56:0]  h1_r;
  logic signed [53:0]  k2_r;
  logic signed [83:0]  k1_r5, k1_r6, k1_r7;
  logic signed [111:0] k0_r5, k0_r6, k0_r7, k0_r8, k0_r9;
  logic signed [57:0]  a2_r;
  logic signed [53:0]  pl_r;
  logic signed [52:0]  ph_r;
  logic signed [83:0]  a1_r;
  logic signed [52:0]  q0_r, q1_r;
  logic signed [51:0]  q2_r;
  logic signed [111:0] acc_r;
  bptc_pkg::out_payload_t out_r;

  bptc_pkg::out_payload_t out_nxt;
  logic signed [23:0] tt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[bptc_pkg::HORNER_STAGES-2:0], temp.valid};
    end
  end

  always_ff @(posedge clk) begin
    t_r[0]   <= temp.t;
    sat_r[0] <= temp.sat;
    for (int i = 1; i < bptc_pkg::HORNER_STAGES - 1; i++) begin
      t_r[i]   <= t_r[i-1];
      sat_r[i] <= sat_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    h1_r  <= 57'(temp.t) * 57'(coef.k3);
    k2_r  <= coef.k2;
    k1_r5 <= coef.k1;
    k0_r5 <= coef.k0;

    a2_r  <= 58'(h1_r) + 58'(k2_r);
    k1_r6 <= k1_r5;
    k0_r6 <= k0_r5;

    pl_r  <= 54'(t_r[1]) * 54'($signed({1'b0, a2_r[28:0]}));
    ph_r  <= 53'(t_r[1]) * 53'($signed(a2_r[57:29]));
    k1_r7 <= k1_r6;
    k0_r7 <= k0_r6;

    a1_r  <= (84'(ph_r) << 29) + 84'(pl_r) + k1_r7;
    k0_r8 <= k0_r7;

    q0_r  <= 53'(t_r[3]) * 53'($signed({1'b0, a1_r[27:0]}));
    q1_r  <= 53'(t_r[3]) * 53'($signed({1'b0, a1_r[55:28]}));
    q2_r  <= 52'(t_r[3]) * 52'($signed(a1_r[83:56]));
    k0_r9 <= k0_r8;

    acc_r <= (112'(q2_r) << 56) + (112'(q1_r) << 28) + 112'(q0_r) + k0_r9
           + (112'(1) << 78);

    out_r <= out_nxt;
  end

  assign tt = t_r[bptc_pkg::HORNER_STAGES-2];

  always_comb begin
    out_nxt.temperature_out = tt;
    out_nxt.saturated       = sat_r[bptc_pkg::HORNER_STAGES-2];
    out_nxt.pressure_out    = acc_r[102:79];
    if (acc_r[111]) begin
      out_nxt.pressure_out = '0;
      out_nxt.saturated    = 1'b1;
    end else if (|acc_r[110:103]) begin
      out_nxt.pressure_out = '1;
      out_nxt.saturated    = 1'b1;
    end
  end

  assign out_valid   = v_r[bptc_pkg::HORNER_STAGES-1];
  assign out_payload = out_r;

endmodule

`default_nettype wire

// File: sv/baro_pressure_temp_compensation.sv
// ---------------------------------------------------------------------------
// baro_pressure_temp_compensation
// Pipelined pressure and temperature compensation from calibration bytes.
// ---------------------------------------------------------------------------
// Usage:
//   Load the three calibration words over the cfg_ channel (cfg_ready is
//   always high; index 0 takes bytes 0 to 7, index 1 bytes 8 to 15, index 2
//   bytes 16 to 20, other indexes are ignored) while no transaction is in
//   flight.
//   A sample pair is taken at each clock edge with start high and busy low.
//   busy is always low, so one transaction may enter every cycle.
//   Each result appears on out_payload for exactly one cycle with out_valid
//   high, after the four temperature stages followed by the seven stages
//   of the pressure cubic.
//   Throughput is one result per cycle. The receiver cannot stall the block.
//   Synchronous reset clears the calibration words and all valid bits; no
//   result is lost after reset other than those in flight when it arrived.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module baro_pressure_temp_compensation (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  output logic                        busy,
  input  wire bptc_pkg::in_payload_t  in_payload,
  output logic                        out_valid,
  output bptc_pkg::out_payload_t      out_payload,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [1:0]             cfg_index,
  input  wire logic [63:0]            cfg_data
);

  logic [63:0] calib_low_r, calib_mid_r;
  logic [39:0] calib_high_r;

  bptc_pkg::calib_t    calib;
  bptc_pkg::temp_res_t temp;
  bptc_pkg::coef_t     coef;
  logic                accept;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      calib_low_r  <= '0;
      calib_mid_r  <= '0;
      calib_high_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        bptc_pkg::CFG_CALIB_LOW:  calib_low_r  <= cfg_data;
        bptc_pkg::CFG_CALIB_MID:  calib_mid_r  <= cfg_data;
        bptc_pkg::CFG_CALIB_HIGH: calib_high_r <= cfg_data[39:0];
        default: ;
      endcase
    end
  end

  assign calib = bptc_pkg::unpack_calib(calib_low_r, calib_mid_r, calib_high_r);

  bptc_temp u_temp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (accept),
    .raw_t    (in_payload.temp_adc),
    .calib    (calib),
    .res      (temp)
  );

  bptc_coef u_coef (
    .clk   (clk),
    .up    (in_payload.press_adc),
    .calib (calib),
    .coef  (coef)
  );

  bptc_horner u_horner (
    .clk         (clk),
    .rst_n       (rst_n),
    .temp        (temp),
    .coef        (coef),
    .out_valid   (out_valid),
    .out_payload (out_payload)
  );

endmodule

`default_nettype wire

// File: sv/bptc_checker.sv
// ---------------------------------------------------------------------------
// bptc_checker
// Port-level timing checks of the compensation block, bound to its top.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module bptc_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire logic out_valid
);

  // Every result strobe answers exactly one earlier transaction.
  `BPTC_ASSERT(a_result_has_source, clk, rst_n, out_valid |-> $past(start && !busy, 11), "result without transaction")
  `BPTC_ASSERT(a_transaction_answered, clk, rst_n, (start && !busy) |-> ##11 out_valid, "transaction lost")
  `BPTC_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |=> !out_valid, "result strobe after reset")

endmodule

bind baro_pressure_temp_compensation bptc_checker u_bptc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid)
);

`default_nettype wire

// File: tb/baro_pressure_temp_compensation_checker.sv
// ---------------------------------------------------------------------------
// baro_pressure_temp_compensation_checker
// Watches the sample, result and calibration channels of the compensation
// block, predicts each compensated pair in wide integer arithmetic and
// compares every result field by field with the oldest prediction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module baro_pressure_temp_compensation_checker (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic                   busy,
  input  bptc_pkg::in_payload_t  in_payload,
  input  logic                   out_valid,
  input  bptc_pkg::out_payload_t out_payload,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [1:0]             cfg_index,
  input  logic [63:0]            cfg_data,
  output int                     errors,
  output int                     pending
);

  typedef logic signed [127:0] acc128_t;

  logic [63:0] calib_low;
  logic [63:0] calib_mid;
  logic [39:0] calib_high;
  bptc_pkg::out_payload_t expected_results[$];

  initial begin
    errors = 0;
    calib_low = '0;
    calib_mid = '0;
    calib_high = '0;
  end

  assign pending = expected_results.size();

  function automatic bptc_pkg::out_payload_t compensate(input bptc_pkg::in_payload_t s);
    logic [167:0] b;
    longint t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9, p10, p11;
    longint up, rt, d, num, tq, tsq, usq;
    acc128_t acc, wt, wu;
    logic sat;
    bptc_pkg::out_payload_t r;
    b = {calib_high, calib_mid, calib_low};
    t1 = b[15:0];
    t2 = b[31:16];
    t3 = $signed(b[39:32]);
    p1 = $signed(b[55:40]) - 16384;
    p2 = $signed(b[71:56]) - 16384;
    p3 = $signed(b[79:72]);
    p4 = $signed(b[87:80]);
    p5 = b[103:88];
    p6 = b[119:104];
    p7 = $signed(b[127:120]);
    p8 = $signed(b[135:128]);
    p9 = $signed(b[151:136]);
    p10 = $signed(b[159:152]);
    p11 = $signed(b[167:160]);
    up = s.press_adc;
    rt = s.temp_adc;
    sat = 1'b0;

    d = rt - t1 * 256;
    num = d * t2 * 262144 + d * d * t3;
    tq = (num + 64'sd2147483648) >>> 32;
    if (tq > 8388607) begin
      tq = 8388607;
      sat = 1'b1;
    end
    if (tq < -8388608) begin
      tq = -8388608;
      sat = 1'b1;
    end

    tsq = tq * tq;
    usq = up * up;
    wt = acc128_t'(tq);
    wu = acc128_t'(up);
    acc = (acc128_t'(p5) <<< 88)
        + (acc128_t'(p6 * tq) <<< 63)
        + (acc128_t'(p7 * tsq) <<< 45)
        + ((acc128_t'(p8 * tsq) * wt) <<< 22)
        + (acc128_t'(up * p1) <<< 65)
        + ((acc128_t'(up * p2) * wt) <<< 40)
        + ((acc128_t'(p3 * tsq) * wu) <<< 21)
        + (acc128_t'(p4 * tsq) * wt * wu)
        + ((acc128_t'(usq) * acc128_t'(p9)) <<< 37)
        + ((acc128_t'(usq * p10) * wt) <<< 21)
        + ((acc128_t'(usq * p11) * wu) <<< 20)
        + (acc128_t'(1) <<< 78);

    if (acc[127]) begin
      r.pressure_out = '0;
      sat = 1'b1;
    end else if (acc[127:79] > 49'hFFFFFF) begin
      r.pressure_out = 24'hFFFFFF;
      sat = 1'b1;
    end else begin
      r.pressure_out = acc[102:79];
    end
    r.temperature_out = tq[23:0];
    r.saturated = sat;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    bptc_pkg::out_payload_t want;
    if (rst_n) begin
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result transaction", 1, 0);
        end else begin
          want = expected_results.pop_front();
          if (out_payload.temperature_out !== want.temperature_out)
            report_mismatch("temperature_out", out_payload.temperature_out,
                            want.temperature_out);
          if (out_payload.pressure_out !== want.pressure_out)
            report_mismatch("pressure_out", out_payload.pressure_out, want.pressure_out);
          if (out_payload.saturated !== want.saturated)
            report_mismatch("saturated", out_payload.saturated, want.saturated);
        end
      end
      if (start && !busy) expected_results.push_back(compensate(in_payload));
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          bptc_pkg::CFG_CALIB_LOW: calib_low = cfg_data;
          bptc_pkg::CFG_CALIB_MID: calib_mid = cfg_data;
          bptc_pkg::CFG_CALIB_HIGH: calib_high = cfg_data[39:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// File: tb/baro_pressure_temp_compensation_tb.sv
// ---------------------------------------------------------------------------
// baro_pressure_temp_compensation_tb
// Drives sample pairs and calibration words into the compensation block
// under several calibration sets, with random idle bursts, and reports
// the verdict from the checker's mismatch count.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module baro_pressure_temp_compensation_tb;

  localparam logic [1:0]  CFG_UNUSED = 2'd3;
  localparam logic [63:0] TYP_LOW = 64'h8E0F1CF948D06A80;
  localparam logic [63:0] TYP_MID = 64'h035E3B4A8C0122FD;
  localparam logic [63:0] TYP_HIGH = 64'h000000F6070F22FA;
  localparam logic [23:0] TYP_RT = 24'h6A8000;
  localparam int ITEMS_PER_PHASE = 340;
  localparam int PHASES = 6;
  localparam int CYCLE_LIMIT = 400000;

  logic                   clk;
  logic                   rst_n;
  logic                   start;
  logic                   busy;
  bptc_pkg::in_payload_t  in_payload;
  logic                   out_valid;
  bptc_pkg::out_payload_t out_payload;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [1:0]             cfg_index;
  logic [63:0]            cfg_data;
  int                     errors;
  int                     pending;
  int                     cycles;
  bit                     idling_on;

  baro_pressure_temp_compensation u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_payload(in_payload),
    .out_valid(out_valid), .out_payload(out_payload), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  baro_pressure_temp_compensation_checker u_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_payload(in_payload),
    .out_valid(out_valid), .out_payload(out_payload), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic write_calib(input logic [1:0] idx, input logic [63:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic send_sample(input logic [23:0] up, input logic [23:0] rt);
    int gap;
    if (idling_on && $urandom_range(0, 5) == 0) begin
      start = 1'b0;
      gap = $urandom_range(1, 16);
      repeat (gap) @(negedge clk);
    end
    start = 1'b1;
    in_payload.press_adc = up;
    in_payload.temp_adc = rt;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic drain;
    start = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (bptc_pkg::LATENCY + 4) @(negedge clk);
  endtask

  initial begin
    logic [23:0] up, rt;
    logic [63:0] lo_w, mid_w, hi_w;
    cycles = 0;
    idling_on = 1'b1;
    rst_n = 1'b0;
    start = 1'b0;
    in_payload = '0;
    cfg_valid = 1'b0;
    cfg_index = bptc_pkg::CFG_CALIB_LOW;
    cfg_data = '0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // Reset calibration, then a realistic set, with field extremes.
    send_sample(24'h000000, 24'h000000);
    send_sample(24'hFFFFFF, 24'hFFFFFF);
    send_sample(24'h000000, 24'hFFFFFF);
    send_sample(24'hFFFFFF, 24'h000000);
    drain();
    write_calib(bptc_pkg::CFG_CALIB_LOW, TYP_LOW);
    write_calib(bptc_pkg::CFG_CALIB_MID, TYP_MID);
    write_calib(bptc_pkg::CFG_CALIB_HIGH, TYP_HIGH | 64'hA5A5A50000000000);
    write_calib(CFG_UNUSED, 64'hFFFFFFFFFFFFFFFF);
    send_sample(24'h000000, 24'h000000);
    send_sample(24'hFFFFFF, 24'hFFFFFF);
    send_sample(24'h000000, 24'hFFFFFF);
    send_sample(24'hFFFFFF, 24'h000000);
    send_sample(24'h6B0000, TYP_RT);
    send_sample(24'h800000, TYP_RT + 24'h040000);
    send_sample(24'h555555, 24'hAAAAAA);
    send_sample(24'hAAAAAA, 24'h555555);
    send_sample(24'h7FFFFF, TYP_RT - 24'h040000);
    send_sample(24'h000001, TYP_RT);
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          lo_w = '1;
          mid_w = '1;
          hi_w = '1;
        end
        1: begin
          lo_w = '0;
          mid_w = '0;
          hi_w = '0;
        end
        2: begin
          lo_w = {$urandom, $urandom};
          mid_w = {$urandom, $urandom};
          hi_w = {$urandom, $urandom};
        end
        default: begin
          lo_w = TYP_LOW ^ {32'h0, 8'h0, 8'($urandom), 16'($urandom_range(0, 255))};
          mid_w = TYP_MID ^ {40'h0, 8'($urandom), 16'h0};
          hi_w = TYP_HIGH ^ {32'h0, $urandom};
        end
      endcase
      if (ph == PHASES - 1) idling_on = 1'b0;
      write_calib(bptc_pkg::CFG_CALIB_HIGH, hi_w);
      write_calib(bptc_pkg::CFG_CALIB_MID, mid_w);
      write_calib(bptc_pkg::CFG_CALIB_LOW, lo_w);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if ($urandom_range(0, 9) < 7) begin
          rt = {lo_w[15:0], 8'h00} + 24'($urandom_range(0, 1 << 20)) - 24'(1 << 19);
          up = 24'($urandom_range(24'h400000, 24'h7FFFFF));
        end else begin
          rt = 24'($urandom);
          up = 24'($urandom);
        end
        send_sample(up, rt);
      end
      drain();
    end

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+sv
sv/bptc_pkg.sv
sv/bptc_temp.sv
sv/bptc_coef.sv
sv/bptc_horner.sv
sv/baro_pressure_temp_compensation.sv
sv/bptc_checker.sv
tb/baro_pressure_temp_compensation_checker.sv
tb/baro_pressure_temp_compensation_tb.sv
